[hdl/resc_pkg.sv]
// Package for the recent event suppression cache: payload and chain token types,
// default sizes and reset constants. No dependencies.
`timescale 1ns / 1ps

package resc_pkg;

   localparam int SLOTS_DEFAULT = 128;
   localparam logic [15:0] MIN_INTERVAL_RESET = 16'd60;

   typedef struct packed {
      logic [31:0] client_address;
      logic [31:0] now_seconds;
   } req_payload_type;

   typedef struct packed {
      logic suppress;
      logic was_present;
   } rsp_payload_type;

   // token walking the cell row; after a hit entry_stamp holds the old time
   typedef struct packed {
      logic        active;
      logic        done;
      logic        hit;
      logic [31:0] entry_address;
      logic [31:0] entry_stamp;
   } chain_token_type;

endpackage

[hdl/resc_cell.sv]
// One cache cell: holds a single (address, time) entry and passes the token on.
// Depends on resc_pkg.
`timescale 1ns / 1ps

module resc_cell
   import resc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [31:0]     key,
   input  chain_token_type tok_in,
   output chain_token_type tok_out
);

   logic            valid_ff, valid_in;
   logic [31:0]     addr_ff, addr_in;
   logic [31:0]     stamp_ff, stamp_in;
   chain_token_type tok_ff, tok_in_next;

   always_comb begin
      valid_in    = valid_ff;
      addr_in     = addr_ff;
      stamp_in    = stamp_ff;
      tok_in_next = tok_in;
      if (tok_in.active && !tok_in.done) begin
         // take the carried entry, hand the old one down unless the walk ends here
         valid_in = 1'b1;
         addr_in  = tok_in.entry_address;
         stamp_in = tok_in.entry_stamp;
         if (valid_ff && (addr_ff == key)) begin
            tok_in_next.done        = 1'b1;
            tok_in_next.hit         = 1'b1;
            tok_in_next.entry_stamp = stamp_ff;
         end else if (!valid_ff) begin
            tok_in_next.done = 1'b1;
            tok_in_next.hit  = 1'b0;
         end else begin
            tok_in_next.entry_address = addr_ff;
            tok_in_next.entry_stamp   = stamp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         tok_ff.active <= tok_in_next.active;
      end
      addr_ff             <= addr_in;
      stamp_ff            <= stamp_in;
      tok_ff.done         <= tok_in_next.done;
      tok_ff.hit          <= tok_in_next.hit;
      tok_ff.entry_address <= tok_in_next.entry_address;
      tok_ff.entry_stamp  <= tok_in_next.entry_stamp;
   end

   assign tok_out = tok_ff;

endmodule

[hdl/recent_event_suppression_cache_unit.sv]
// Top level of the recent event suppression cache: cell row, item control, result buffer.
// Depends on resc_pkg and resc_cell.
`timescale 1ns / 1ps
//
//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------------
//  req     | req_valid/req_ready/req_data   | item: client_address, now_seconds
//  rsp     | rsp_valid/rsp_ready/rsp_data   | item: suppress, was_present
//  csr     | csr_write_enable/csr_write_data| repeat window, written any cycle
//
//  An item walks the row of SLOTS-1 cells, one cell per cycle, always to the end.
//  The result is registered into the output register once the token leaves the row;
//  a new item is taken only after the previous one has left the row.
//  One result is held in a side buffer, so a stalled rsp side blocks req only
//  after two results wait. Synchronous reset empties every cell at once.

module recent_event_suppression_cache_unit
   import resc_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_write_enable,
   input  logic [15:0]     csr_write_data
);

   localparam int CELLS = SLOTS - 1;

   logic            busy_ff, busy_in;
   logic [31:0]     key_ff;
   logic [31:0]     now_ff;
   logic [15:0]     interval_ff;
   chain_token_type inject_ff, inject_in;
   chain_token_type tok [0:CELLS];

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   logic            hold_valid_ff, hold_valid_in;
   rsp_payload_type hold_data_ff, hold_data_in;

   logic            accept;
   logic            exit_active;
   logic [32:0]     limit;
   rsp_payload_type result;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff && !hold_valid_ff;

   assign tok[0] = inject_ff;

   genvar g;
   generate
      for (g = 0; g < CELLS; g++) begin : g_cell
         resc_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .key     (key_ff),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
         );
      end
   endgenerate

   assign exit_active = tok[CELLS].active;
   assign limit = {1'b0, tok[CELLS].entry_stamp} + {17'd0, interval_ff};

   always_comb begin
      result.was_present = tok[CELLS].done && tok[CELLS].hit;
      result.suppress    = result.was_present && (limit >= {1'b0, now_ff});

      inject_in               = inject_ff;
      inject_in.active        = accept;
      inject_in.done          = 1'b0;
      inject_in.hit           = 1'b0;
      inject_in.entry_address = req_data.client_address;
      inject_in.entry_stamp   = req_data.now_seconds;

      busy_in       = busy_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;

      if (accept) begin
         busy_in = 1'b1;
      end
      // drain the output register, refill from the side buffer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = hold_valid_ff;
         rsp_data_in  = hold_data_ff;
         hold_valid_in = 1'b0;
      end
      if (exit_active) begin
         busy_in = 1'b0;
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = result;
         end else begin
            hold_valid_in = 1'b1;
            hold_data_in  = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff          <= 1'b0;
         inject_ff.active <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         hold_valid_ff    <= 1'b0;
         interval_ff      <= MIN_INTERVAL_RESET;
      end else begin
         busy_ff          <= busy_in;
         inject_ff.active <= inject_in.active;
         rsp_valid_ff     <= rsp_valid_in;
         hold_valid_ff    <= hold_valid_in;
         if (csr_write_enable) begin
            interval_ff <= csr_write_data;
         end
      end
      inject_ff.done          <= inject_in.done;
      inject_ff.hit           <= inject_in.hit;
      inject_ff.entry_address <= inject_in.entry_address;
      inject_ff.entry_stamp   <= inject_in.entry_stamp;
      rsp_data_ff             <= rsp_data_in;
      hold_data_ff            <= hold_data_in;
      if (accept) begin
         key_ff <= req_data.client_address;
         now_ff <= req_data.now_seconds;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("item accepted but block not busy");

   a_exit_busy : assert property (@(posedge clock) disable iff (reset)
      exit_active |-> busy_ff)
      else $error("token left the cell row with no item in flight");

   a_exit_hold_free : assert property (@(posedge clock) disable iff (reset)
      exit_active |-> !hold_valid_ff)
      else $error("result arrived with side buffer occupied");

   a_suppress_hit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.suppress && !rsp_data_ff.was_present))
      else $error("suppress raised for an address not present");

endmodule
